>>> rtl/triangle_face_normal_unit_defines.svh
// assertion macros shared by the face normal rtl
`ifndef TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TFN_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tfn check failed");

// next-cycle implication, checked outside reset
`define TFN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tfn check failed");

`endif

>>> rtl/tfn_pkg.sv
// widths, types and helper functions of the face normal pipeline
`default_nettype none
package tfn_pkg;
	localparam int COORD_WIDTH  = 24;
	localparam int NORMAL_WIDTH = 16;
	localparam int FRAC         = NORMAL_WIDTH - 2;
	localparam int EDGE_W       = COORD_WIDTH + 1;
	localparam int PROD_W       = 2 * EDGE_W;
	localparam int CROSS_W      = PROD_W + 1;
	localparam int MAG_W        = CROSS_W;
	localparam int LEN_W        = $clog2(MAG_W + 1);
	localparam int SCALE_BITS   = 30;
	localparam int SQ_W         = 2 * SCALE_BITS;
	localparam int SUM_W        = SQ_W + 2;
	localparam int ROOT_W       = SUM_W / 2;
	localparam int DEN_W        = ROOT_W + 1;
	localparam int Q_W          = FRAC + 1;
	localparam int NUM_W        = SCALE_BITS + FRAC + 2;
	localparam int IN_W         = 9 * COORD_WIDTH;
	localparam int OUT_W        = ((3 * NORMAL_WIDTH + 7) / 8) * 8;

	typedef logic [SCALE_BITS-1:0] mant_t;

	typedef struct packed {
		logic [2:0]       neg;
		logic             degen;
		logic [2:0][SCALE_BITS-1:0] m;
	} side_t;

	// position of the leading one plus one, zero for a zero word
	function automatic logic [LEN_W-1:0] bit_len(input logic [MAG_W-1:0] v);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (v[i]) n = LEN_W'(i + 1);
		end
		return n;
	endfunction
endpackage
`default_nettype wire

>>> rtl/tfn_cross.sv
// edge vectors, cross product and component magnitudes (four stages)
`default_nettype none
module tfn_cross (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [2:0][2:0][tfn_pkg::COORD_WIDTH-1:0] corner,
	output logic out_valid,
	output logic [2:0][tfn_pkg::MAG_W-1:0] out_mag,
	output logic [2:0] out_neg
);
	import tfn_pkg::*;

	logic signed [EDGE_W-1:0]  e1_s1 [3];
	logic signed [EDGE_W-1:0]  e2_s1 [3];
	logic signed [PROD_W-1:0]  pa_s2 [3];
	logic signed [PROD_W-1:0]  pb_s2 [3];
	logic signed [CROSS_W-1:0] cr_s3 [3];
	logic [MAG_W-1:0] mag_s4 [3];
	logic [2:0] neg_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= $signed({corner[1][i][COORD_WIDTH-1], corner[1][i]})
					- $signed({corner[0][i][COORD_WIDTH-1], corner[0][i]});
				e2_s1[i] <= $signed({corner[2][i][COORD_WIDTH-1], corner[2][i]})
					- $signed({corner[0][i][COORD_WIDTH-1], corner[0][i]});
			end
			for (int i = 0; i < 3; i++) begin
				pa_s2[i] <= e1_s1[(i + 1) % 3] * e2_s1[(i + 2) % 3];
				pb_s2[i] <= e1_s1[(i + 2) % 3] * e2_s1[(i + 1) % 3];
			end
			for (int i = 0; i < 3; i++) begin
				cr_s3[i] <= $signed({pa_s2[i][PROD_W-1], pa_s2[i]})
					- $signed({pb_s2[i][PROD_W-1], pb_s2[i]});
			end
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= cr_s3[i][CROSS_W-1];
				mag_s4[i] <= cr_s3[i][CROSS_W-1] ? MAG_W'(-cr_s3[i]) : MAG_W'(cr_s3[i]);
			end
		end
	end

	assign out_valid = valid_s4;
	assign out_neg   = neg_s4;
	always_comb begin
		for (int i = 0; i < 3; i++) out_mag[i] = mag_s4[i];
	end
endmodule
`default_nettype wire

>>> rtl/tfn_scale.sv
// leading one search, scaling to 30 bits, squares and their sum (four stages)
`default_nettype none
module tfn_scale (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [2:0][tfn_pkg::MAG_W-1:0] in_mag,
	input  wire logic [2:0] in_neg,
	output logic out_valid,
	output logic [tfn_pkg::SUM_W-1:0] out_sum,
	output tfn_pkg::side_t out_side
);
	import tfn_pkg::*;

	logic [2:0][MAG_W-1:0] mag_s5;
	logic [LEN_W-1:0] len_s5;
	logic [2:0] neg_s5;
	side_t side_s6, side_s7, side_s8;
	logic [SQ_W-1:0] sq_s7 [3];
	logic [SUM_W-1:0] sum_s8;
	logic valid_s5, valid_s6, valid_s7, valid_s8;
	logic [LEN_W-1:0] sh;
	logic [MAG_W-1:0] norm [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s5 <= in_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// leading one lands on the top bit, the top 30 bits are kept
	always_comb begin
		sh = LEN_W'(MAG_W) - len_s5;
		for (int i = 0; i < 3; i++) norm[i] = mag_s5[i] << sh;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5 <= in_mag;
			neg_s5 <= in_neg;
			len_s5 <= bit_len(in_mag[0] | in_mag[1] | in_mag[2]);

			side_s6.neg   <= neg_s5;
			side_s6.degen <= (len_s5 == '0);
			for (int i = 0; i < 3; i++) side_s6.m[i] <= norm[i][MAG_W-1 -: SCALE_BITS];

			side_s7 <= side_s6;
			for (int i = 0; i < 3; i++) sq_s7[i] <= side_s6.m[i] * side_s6.m[i];

			side_s8 <= side_s7;
			sum_s8 <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
		end
	end

	assign out_valid = valid_s8;
	assign out_sum   = sum_s8;
	assign out_side  = side_s8;
endmodule
`default_nettype wire

>>> rtl/tfn_isqrt.sv
// floor square root, one result bit per pipeline stage
`default_nettype none
module tfn_isqrt (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [tfn_pkg::SUM_W-1:0] in_sum,
	input  wire tfn_pkg::side_t in_side,
	output logic out_valid,
	output logic [tfn_pkg::ROOT_W-1:0] out_root,
	output tfn_pkg::side_t out_side
);
	import tfn_pkg::*;

	logic [SUM_W-1:0]  rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];
	side_t             side_s [ROOT_W+1];
	logic [ROOT_W:0]   valid_s;

	assign rem_s[0]   = in_sum;
	assign root_s[0]  = '0;
	assign side_s[0]  = in_side;
	assign valid_s[0] = in_valid;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		localparam int B = ROOT_W - 1 - k;
		logic [SUM_W-1:0] trial;
		assign trial = (SUM_W'(root_s[k]) << (B + 1)) + (SUM_W'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				if (rem_s[k] >= trial) begin
					rem_s[k+1]  <= rem_s[k] - trial;
					root_s[k+1] <= root_s[k] | (ROOT_W'(1) << B);
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k];
				end
			end
		end
	end

	assign out_valid = valid_s[ROOT_W];
	assign out_root  = root_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];
endmodule
`default_nettype wire

>>> rtl/tfn_div.sv
// rounded quotients m * 2^15 / (2 r), three lanes, one quotient bit per stage
`default_nettype none
module tfn_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [tfn_pkg::ROOT_W-1:0] in_root,
	input  wire tfn_pkg::side_t in_side,
	output logic out_valid,
	output logic [2:0][tfn_pkg::Q_W-1:0] out_q,
	output tfn_pkg::side_t out_side
);
	import tfn_pkg::*;

	logic [2:0][NUM_W-1:0] num_s  [Q_W+1];
	logic [2:0][Q_W-1:0]   q_s    [Q_W+1];
	logic [DEN_W-1:0]      den_s  [Q_W+1];
	side_t                 side_s [Q_W+1];
	logic [Q_W:0]          valid_s;

	// adding r first turns the floor into round to nearest
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_s[0][i] = (NUM_W'(in_side.m[i]) << (FRAC + 1)) + NUM_W'(in_root);
		end
	end
	assign q_s[0]     = '0;
	assign den_s[0]   = {in_root, 1'b0};
	assign side_s[0]  = in_side;
	assign valid_s[0] = in_valid;

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		localparam int J = Q_W - 1 - k;
		logic [NUM_W-1:0] trial;
		assign trial = NUM_W'(den_s[k]) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				den_s[k+1]  <= den_s[k];
				for (int i = 0; i < 3; i++) begin
					if (num_s[k][i] >= trial) begin
						num_s[k+1][i] <= num_s[k][i] - trial;
						q_s[k+1][i]   <= q_s[k][i] | (Q_W'(1) << J);
					end else begin
						num_s[k+1][i] <= num_s[k][i];
						q_s[k+1][i]   <= q_s[k][i];
					end
				end
			end
		end
	end

	assign out_valid = valid_s[Q_W];
	assign out_q     = q_s[Q_W];
	assign out_side  = side_s[Q_W];
endmodule
`default_nettype wire

>>> rtl/triangle_face_normal_unit.sv
// unit face normal of a triangle: top level with output register and stall control
// throughput: one triangle per cycle; the whole pipeline holds while the output word waits
// stages: 4 cross product, 4 scaling, 31 square root bits, 15 quotient bits, 1 output
// reset clears every valid bit at once; payload registers keep no reset
`default_nettype none
`include "triangle_face_normal_unit_defines.svh"
module triangle_face_normal_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
	input  wire logic [tfn_pkg::IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input  wire logic m_tready,
	// normal_x, normal_y, normal_z
	output logic [tfn_pkg::OUT_W-1:0] m_tdata,
	// degenerate
	output logic m_tuser
);
	import tfn_pkg::*;

	logic en;
	logic cr_valid, sc_valid, sq_valid, dv_valid;
	logic [2:0][MAG_W-1:0] cr_mag;
	logic [2:0] cr_neg;
	logic [SUM_W-1:0] sc_sum;
	side_t sc_side, sq_side, dv_side;
	logic [ROOT_W-1:0] sq_root;
	logic [2:0][Q_W-1:0] dv_q;
	logic out_valid_q;
	logic [2:0][NORMAL_WIDTH-1:0] normal_q;
	logic degen_q;
	logic [NORMAL_WIDTH-1:0] mag_n [3];

	assign en       = m_tready || !out_valid_q;
	assign s_tready = en;

	tfn_cross u_cross (
		.clk, .arst_n, .en,
		.in_valid  (s_tvalid),
		.corner    (s_tdata),
		.out_valid (cr_valid),
		.out_mag   (cr_mag),
		.out_neg   (cr_neg)
	);

	tfn_scale u_scale (
		.clk, .arst_n, .en,
		.in_valid  (cr_valid),
		.in_mag    (cr_mag),
		.in_neg    (cr_neg),
		.out_valid (sc_valid),
		.out_sum   (sc_sum),
		.out_side  (sc_side)
	);

	tfn_isqrt u_isqrt (
		.clk, .arst_n, .en,
		.in_valid  (sc_valid),
		.in_sum    (sc_sum),
		.in_side   (sc_side),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	tfn_div u_div (
		.clk, .arst_n, .en,
		.in_valid  (sq_valid),
		.in_root   (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.out_q     (dv_q),
		.out_side  (dv_side)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) mag_n[i] = NORMAL_WIDTH'(dv_q[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_q <= dv_side.degen;
			for (int i = 0; i < 3; i++) begin
				if (dv_side.degen) begin
					normal_q[i] <= '0;
				end else if (dv_side.neg[i]) begin
					normal_q[i] <= -mag_n[i];
				end else begin
					normal_q[i] <= mag_n[i];
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(normal_q);
	assign m_tuser  = degen_q;

	`TFN_ASSERT_NOW(a_degen_zero, m_tvalid && m_tuser, m_tdata == '0)
	`TFN_ASSERT_NOW(a_empty_accepts, !m_tvalid, s_tready)
	`TFN_ASSERT_NOW(a_quot_range, dv_valid && !dv_side.degen,
		(dv_q[0] <= Q_W'(1 << FRAC)) && (dv_q[1] <= Q_W'(1 << FRAC))
		&& (dv_q[2] <= Q_W'(1 << FRAC)))
	`TFN_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
`default_nettype wire
